[hw/rtl/dpar_pkg.sv]
// Shared types and constants for the direction pad auto-repeat block.
package dpar_pkg;

	// Field widths
	localparam int unsigned DIR_W   = 4;
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned REG_W   = 24;
	localparam int unsigned FIRE_W  = 3;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned OUT_TDATA_W = 8;

	// Direction bit positions in held_dirs and pressed_dirs
	localparam int unsigned DIR_UP_BIT    = 0;
	localparam int unsigned DIR_DOWN_BIT  = 1;
	localparam int unsigned DIR_LEFT_BIT  = 2;
	localparam int unsigned DIR_RIGHT_BIT = 3;

	// Fired direction codes
	localparam logic [FIRE_W-1:0] FIRE_NONE  = 3'd0;
	localparam logic [FIRE_W-1:0] FIRE_DOWN  = 3'd1;
	localparam logic [FIRE_W-1:0] FIRE_UP    = 3'd2;
	localparam logic [FIRE_W-1:0] FIRE_RIGHT = 3'd3;
	localparam logic [FIRE_W-1:0] FIRE_LEFT  = 3'd4;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_INITIAL_DELAY = 3'd0;
	localparam logic [IDX_W-1:0] REG_BASE_PERIOD   = 3'd1;
	localparam logic [IDX_W-1:0] REG_FAST_THR_ONE  = 3'd2;
	localparam logic [IDX_W-1:0] REG_FAST_THR_TWO  = 3'd3;
	localparam logic [IDX_W-1:0] REG_MIDDLE_PERIOD = 3'd4;
	localparam logic [IDX_W-1:0] REG_MINIMUM_PERIOD = 3'd5;

	// Register reset values, microseconds
	localparam logic [REG_W-1:0] RST_INITIAL_DELAY  = 24'd267000;
	localparam logic [REG_W-1:0] RST_BASE_PERIOD    = 24'd100000;
	localparam logic [REG_W-1:0] RST_FAST_THR_ONE   = 24'd600000;
	localparam logic [REG_W-1:0] RST_FAST_THR_TWO   = 24'd1600000;
	localparam logic [REG_W-1:0] RST_MIDDLE_PERIOD  = 24'd66700;
	localparam logic [REG_W-1:0] RST_MINIMUM_PERIOD = 24'd33300;

	// One frame sample as packed in the input tdata
	typedef struct packed {
		logic [STAMP_W-1:0] timestamp;
		logic [DIR_W-1:0]   pressed_dirs;
		logic [DIR_W-1:0]   held_dirs;
	} sample_t;

	// Priority pick: down, up, right, left
	function automatic logic [FIRE_W-1:0] pick_code(input logic [DIR_W-1:0] dirs);
		logic [FIRE_W-1:0] code;
		code = FIRE_NONE;
		if (dirs[DIR_DOWN_BIT])
			code = FIRE_DOWN;
		else if (dirs[DIR_UP_BIT])
			code = FIRE_UP;
		else if (dirs[DIR_RIGHT_BIT])
			code = FIRE_RIGHT;
		else if (dirs[DIR_LEFT_BIT])
			code = FIRE_LEFT;
		return code;
	endfunction

endpackage

[hw/rtl/dpad_auto_repeat_accelerating.sv]
// Direction pad auto-repeat with two-step acceleration: top level.
//
// Usage: one frame sample per transfer on the s_axis side (held directions,
// newly pressed directions, microsecond timestamp); one fired direction per
// sample on the m_axis side (0 none, 1 down, 2 up, 3 right, 4 left). Six
// 24-bit timing registers are written through cfg_we / cfg_addr / cfg_wdata;
// the user must write them only while no sample is in flight (unchecked).
// Path: an accepted sample moves from the input register to the result
// register once that register is empty or its result is being taken.
// Throughput: one sample per cycle unless the receiver stalls;
// the repeat state is updated in the single cycle in which a sample moves
// from the input register to the result register.
// Stall: when the receiver holds m_tready low the result register holds,
// the input register takes one more sample, and s_tready then drops until
// the result is taken.
// Reset: arst_n clears both valid flags and the repeat state (no stamp seen,
// zero hold time and countdown, nothing held) and loads the timing register
// defaults.
module dpad_auto_repeat_accelerating (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port
	input  logic                          cfg_we,
	input  logic [dpar_pkg::IDX_W-1:0]    cfg_addr,
	input  logic [dpar_pkg::REG_W-1:0]    cfg_wdata,
	// Sample input
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// tdata: held_dirs [3:0], pressed_dirs [7:4], timestamp [39:8]
	input  logic [dpar_pkg::IN_TDATA_W-1:0]  s_tdata,
	// Result output
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// tdata: fired_dir [2:0], zero fill [7:3]
	output logic [dpar_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import dpar_pkg::*;

	localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

	// Timing registers
	logic [REG_W-1:0] initial_delay_q;
	logic [REG_W-1:0] base_period_q;
	logic [REG_W-1:0] fast_thr_one_q;
	logic [REG_W-1:0] fast_thr_two_q;
	logic [REG_W-1:0] middle_period_q;
	logic [REG_W-1:0] minimum_period_q;

	// Repeat state
	logic [STAMP_W-1:0] last_stamp_q;
	logic [STAMP_W-1:0] hold_q;
	logic [REG_W-1:0]   countdown_q;
	logic [DIR_W-1:0]   prev_dirs_q;

	// Input register and result register
	logic               valid_s1;
	sample_t            sample_s1;
	logic               out_valid_q;
	logic [FIRE_W-1:0]  fired_q;

	logic s_xfer;
	logic advance;

	// Next-state values
	logic [STAMP_W-1:0] dt;
	logic [STAMP_W:0]   hold_sum;
	logic [STAMP_W-1:0] hold_sat;
	logic [REG_W:0]     limit_one;
	logic [REG_W:0]     limit_two;
	logic [REG_W-1:0]   period;
	logic               expired;
	logic               fire;
	logic [DIR_W-1:0]   fire_dirs;
	logic [STAMP_W-1:0] hold_nx;
	logic [REG_W-1:0]   countdown_nx;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_xfer   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-FIRE_W){1'b0}}, fired_q};

	// Write timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_delay_q  <= RST_INITIAL_DELAY;
			base_period_q    <= RST_BASE_PERIOD;
			fast_thr_one_q   <= RST_FAST_THR_ONE;
			fast_thr_two_q   <= RST_FAST_THR_TWO;
			middle_period_q  <= RST_MIDDLE_PERIOD;
			minimum_period_q <= RST_MINIMUM_PERIOD;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_INITIAL_DELAY:  initial_delay_q  <= cfg_wdata;
				REG_BASE_PERIOD:    base_period_q    <= cfg_wdata;
				REG_FAST_THR_ONE:   fast_thr_one_q   <= cfg_wdata;
				REG_FAST_THR_TWO:   fast_thr_two_q   <= cfg_wdata;
				REG_MIDDLE_PERIOD:  middle_period_q  <= cfg_wdata;
				REG_MINIMUM_PERIOD: minimum_period_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Hold the sample in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			sample_s1 <= sample_t'(s_tdata);
		end
	end

	// Compare hold time against delay plus threshold, no subtract needed
	assign limit_one = {1'b0, initial_delay_q} + {1'b0, fast_thr_one_q};
	assign limit_two = {1'b0, initial_delay_q} + {1'b0, fast_thr_two_q};

	// Elapsed time, saturating hold, countdown expiry, period pick and fire decision
	always_comb begin
		dt       = (last_stamp_q != '0) ? sample_s1.timestamp - last_stamp_q : '0;
		hold_sum = {1'b0, hold_q} + {1'b0, dt};
		hold_sat = hold_sum[STAMP_W] ? STAMP_MAX : hold_sum[STAMP_W-1:0];
		expired  = dt >= {{(STAMP_W-REG_W){1'b0}}, countdown_q};
		if (hold_sat > {{(STAMP_W-REG_W-1){1'b0}}, limit_two})
			period = minimum_period_q;
		else if (hold_sat > {{(STAMP_W-REG_W-1){1'b0}}, limit_one})
			period = middle_period_q;
		else
			period = base_period_q;

		fire         = 1'b0;
		fire_dirs    = sample_s1.held_dirs;
		hold_nx      = hold_q;
		countdown_nx = countdown_q;
		if (sample_s1.pressed_dirs != '0) begin
			fire         = 1'b1;
			fire_dirs    = sample_s1.pressed_dirs;
			hold_nx      = '0;
			countdown_nx = initial_delay_q;
		end else if (sample_s1.held_dirs != prev_dirs_q) begin
			fire         = sample_s1.held_dirs != '0;
			hold_nx      = '0;
			countdown_nx = initial_delay_q;
		end else if (sample_s1.held_dirs != '0) begin
			hold_nx = hold_sat;
			if (expired) begin
				fire         = 1'b1;
				countdown_nx = period;
			end else begin
				countdown_nx = countdown_q - dt[REG_W-1:0];
			end
		end
	end

	// Advance the repeat state as the sample leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_stamp_q <= '0;
			hold_q       <= '0;
			countdown_q  <= '0;
			prev_dirs_q  <= '0;
		end else if (advance) begin
			last_stamp_q <= (sample_s1.timestamp != '0) ? sample_s1.timestamp
				: {{(STAMP_W-1){1'b0}}, 1'b1};
			hold_q       <= hold_nx;
			countdown_q  <= countdown_nx;
			prev_dirs_q  <= sample_s1.held_dirs;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fired_q <= fire ? pick_code(fire_dirs) : FIRE_NONE;
		end
	end

	// A fresh press always fires and clears the hold time
	a_press_fires: assert property (@(posedge clk) disable iff (!arst_n)
		advance && sample_s1.pressed_dirs != '0
		|=> out_valid_q && fired_q != FIRE_NONE && hold_q == '0)
		else $error("fresh press did not fire or clear hold time");

	// Once a sample has passed, the stored stamp reads as a valid reading
	a_stamp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> last_stamp_q != '0)
		else $error("stored stamp is zero after a sample");

	// Input side stalls only with a sample waiting on a full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && out_valid_q && !m_tready)
		else $error("input stalled without cause");

	// Fired code stays in its range
	a_fired_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> fired_q <= FIRE_LEFT)
		else $error("fired direction out of range");

	// A changed held set always re-arms the countdown to the initial delay
	a_change_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		advance && sample_s1.held_dirs != prev_dirs_q
		|=> countdown_q == $past(initial_delay_q))
		else $error("held set change did not re-arm countdown");

endmodule

[dv/dpad_fire_checker.sv]
`timescale 1ns / 100ps
// Transfer checker for the direction pad auto-repeat block: predicts and compares fired directions.
module dpad_fire_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dpar_pkg::IDX_W-1:0]       cfg_addr,
	input  logic [dpar_pkg::REG_W-1:0]       cfg_wdata,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	// tdata: held_dirs [3:0], pressed_dirs [7:4], timestamp [39:8]
	input  logic [dpar_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	// tdata: fired_dir [2:0], zero fill [7:3]
	input  logic [dpar_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int                               fail_count,
	output int                               pending
);
	import dpar_pkg::*;

	// Timing registers, widened to the stamp width
	logic [STAMP_W-1:0] delay_us, base_us, thr_one_us, thr_two_us, mid_us, min_us;

	// Repeat state
	logic [STAMP_W-1:0] stamp_prev;
	logic [STAMP_W-1:0] hold_us;
	logic [STAMP_W-1:0] remain_us;
	logic [DIR_W-1:0]   dirs_prev;

	// Fired directions still owed by the block, oldest first
	logic [FIRE_W-1:0]      fired_q[$];
	sample_t                smp;
	logic [OUT_TDATA_W-1:0] want;

	// Resolve a direction set by priority: down, up, right, left
	function automatic logic [FIRE_W-1:0] resolve_dir(input logic [DIR_W-1:0] dirs);
		if (dirs[DIR_DOWN_BIT])
			return FIRE_DOWN;
		if (dirs[DIR_UP_BIT])
			return FIRE_UP;
		if (dirs[DIR_RIGHT_BIT])
			return FIRE_RIGHT;
		if (dirs[DIR_LEFT_BIT])
			return FIRE_LEFT;
		return FIRE_NONE;
	endfunction

	// Pick the repeat period from the time spent repeating so far
	function automatic logic [STAMP_W-1:0] repeat_period(input logic [STAMP_W-1:0] hold);
		logic [STAMP_W-1:0] repeating;
		repeating = (hold > delay_us) ? hold - delay_us : '0;
		if (repeating > thr_two_us)
			return min_us;
		if (repeating > thr_one_us)
			return mid_us;
		return base_us;
	endfunction

	// Advance the repeat state by one frame and return the direction it fires
	function automatic logic [FIRE_W-1:0] next_fire(input logic [DIR_W-1:0] held,
			input logic [DIR_W-1:0] pressed, input logic [STAMP_W-1:0] now);
		logic [STAMP_W-1:0] elapsed;
		logic [DIR_W-1:0]   dirs;
		logic               fire;
		dirs = held;
		fire = 1'b0;
		elapsed = (stamp_prev != '0) ? now - stamp_prev : '0;
		stamp_prev = (now != '0) ? now : STAMP_W'(1);
		if (pressed != '0) begin
			// fresh press wins; the pressed set picks the direction
			dirs = pressed;
			fire = 1'b1;
			hold_us = '0;
			remain_us = delay_us;
		end else if (held != dirs_prev) begin
			hold_us = '0;
			remain_us = delay_us;
			fire = (held != '0);
		end else if (held != '0) begin
			// saturate hold time, then count down
			hold_us = (hold_us > ~elapsed) ? '1 : hold_us + elapsed;
			if (elapsed >= remain_us) begin
				fire = 1'b1;
				remain_us = repeat_period(hold_us);
			end else begin
				remain_us = remain_us - elapsed;
			end
		end
		dirs_prev = held;
		return fire ? resolve_dir(dirs) : FIRE_NONE;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_us   = {8'd0, RST_INITIAL_DELAY};
			base_us    = {8'd0, RST_BASE_PERIOD};
			thr_one_us = {8'd0, RST_FAST_THR_ONE};
			thr_two_us = {8'd0, RST_FAST_THR_TWO};
			mid_us     = {8'd0, RST_MIDDLE_PERIOD};
			min_us     = {8'd0, RST_MINIMUM_PERIOD};
			stamp_prev = '0;
			hold_us    = '0;
			remain_us  = '0;
			dirs_prev  = '0;
			fired_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			// Compare a result transfer with the oldest expectation
			if (m_tvalid && m_tready) begin
				if (fired_q.size() == 0) begin
					$display("%0t: result transfer %h with nothing expected", $time, m_tdata);
					fail_count++;
				end else begin
					want = '0;
					want[FIRE_W-1:0] = fired_q.pop_front();
					if (m_tdata !== want) begin
						$display("%0t: fired_dir expected %0d (tdata %h), got %0d (tdata %h)",
							$time, want[FIRE_W-1:0], want, m_tdata[FIRE_W-1:0], m_tdata);
						fail_count++;
					end
				end
			end
			// Predict the result of a sample transfer
			if (s_tvalid && s_tready) begin
				smp = s_tdata;
				fired_q.push_back(next_fire(smp.held_dirs, smp.pressed_dirs, smp.timestamp));
			end
			// Track register writes
			if (cfg_we) begin
				case (cfg_addr)
					REG_INITIAL_DELAY:  delay_us   = {8'd0, cfg_wdata};
					REG_BASE_PERIOD:    base_us    = {8'd0, cfg_wdata};
					REG_FAST_THR_ONE:   thr_one_us = {8'd0, cfg_wdata};
					REG_FAST_THR_TWO:   thr_two_us = {8'd0, cfg_wdata};
					REG_MIDDLE_PERIOD:  mid_us     = {8'd0, cfg_wdata};
					REG_MINIMUM_PERIOD: min_us     = {8'd0, cfg_wdata};
					default: ;
				endcase
			end
			pending = fired_q.size();
		end
	end

endmodule

[dv/dpad_auto_repeat_accelerating_test.sv]
`timescale 1ns / 100ps
// Testbench top for the direction pad auto-repeat block: stimulus, idling and verdict.
module dpad_auto_repeat_accelerating_test;
	import dpar_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [IDX_W-1:0]       cfg_addr;
	logic [REG_W-1:0]       cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	// tdata: held_dirs [3:0], pressed_dirs [7:4], timestamp [39:8]
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	// tdata: fired_dir [2:0], zero fill [7:3]
	logic [OUT_TDATA_W-1:0] m_tdata;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left;
	int items_sent = 0;
	bit hold_off_req = 1'b0;
	logic [STAMP_W-1:0] clock_us;

	dpad_auto_repeat_accelerating u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	dpad_fire_checker u_fire_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

	// Receiver: random stalls, or a long hold-off on request
	initial begin
		m_tready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = 200;
			end
			if (hold_left > 0) begin
				m_tready = 1'b0;
				hold_left--;
			end else begin
				m_tready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Offer one sample and hold it until the transfer
	task automatic send_sample(input logic [DIR_W-1:0] held, input logic [DIR_W-1:0] pressed,
			input logic [STAMP_W-1:0] ts);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tdata = sample_t'{timestamp: ts, pressed_dirs: pressed, held_dirs: held};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		@(negedge clk);
	endtask

	// Advance the frame clock by a random step and send one sample
	task automatic play(input logic [DIR_W-1:0] held, input logic [DIR_W-1:0] pressed);
		logic [STAMP_W-1:0] dt;
		int r;
		r = $urandom_range(99);
		if (r < 55)
			dt = $urandom_range(16000, 17400);
		else if (r < 75)
			dt = $urandom_range(0, 3000);
		else if (r < 90)
			dt = $urandom_range(3000, 400000);
		else if (r < 97)
			dt = $urandom_range(400000, 32'h0200_0000);
		else
			dt = $urandom;
		clock_us = clock_us + dt;
		if ($urandom_range(99) == 0)
			clock_us = '0;
		send_sample(held, pressed, clock_us);
	endtask

	// Drop valid and wait until every owed result has come back
	task automatic drain();
		s_tvalid = 1'b0;
		wait (pending == 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		@(negedge clk);
	endtask

	// Load all six timing registers while the block is idle
	task automatic apply_setting(input logic [REG_W-1:0] delay, input logic [REG_W-1:0] base,
			input logic [REG_W-1:0] thr_one, input logic [REG_W-1:0] thr_two,
			input logic [REG_W-1:0] middle, input logic [REG_W-1:0] minimum);
		drain();
		write_reg(REG_INITIAL_DELAY, delay);
		write_reg(REG_BASE_PERIOD, base);
		write_reg(REG_FAST_THR_ONE, thr_one);
		write_reg(REG_FAST_THR_TWO, thr_two);
		write_reg(REG_MIDDLE_PERIOD, middle);
		write_reg(REG_MINIMUM_PERIOD, minimum);
		cfg_we = 1'b0;
		@(negedge clk);
	endtask

	// Mostly press, hold and release sequences; some idle frames and noise
	task automatic random_phase(input int target);
		int start;
		int len;
		int r;
		logic [DIR_W-1:0] dirs;
		start = items_sent;
		while (items_sent - start < target) begin
			r = $urandom_range(99);
			if (r < 75) begin
				dirs = ($urandom_range(99) < 70) ? DIR_W'(1 << $urandom_range(3))
					: DIR_W'($urandom_range(1, 15));
				play(dirs, ($urandom_range(99) < 20) ? DIR_W'($urandom_range(1, 15)) : dirs);
				len = ($urandom_range(99) < 8) ? $urandom_range(100, 160) : $urandom_range(2, 40);
				repeat (len) begin
					r = $urandom_range(99);
					if (r < 4) begin
						dirs = DIR_W'($urandom_range(1, 15));
						play(dirs, '0);
					end else if (r < 7) begin
						play(dirs, DIR_W'($urandom_range(1, 15)));
					end else begin
						play(dirs, '0);
					end
				end
				repeat ($urandom_range(1, 3)) play('0, '0);
			end else if (r < 85) begin
				play('0, '0);
			end else begin
				play(DIR_W'($urandom_range(15)), DIR_W'($urandom_range(15)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		clock_us = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed frames on the reset timing
		send_sample(4'h0, 4'h0, 32'h0);           // first sample, zero stamp
		send_sample(4'h3, 4'h3, 32'd1000);        // diagonal press fires down
		send_sample(4'h3, 4'h0, 32'd101000);      // steady, counting down
		send_sample(4'h3, 4'h0, 32'd268000);      // elapsed equals countdown
		send_sample(4'h3, 4'h0, 32'd368000);      // base period repeat
		send_sample(4'h4, 4'h8, 32'd370000);      // press with change: pressed set decides
		send_sample(4'hC, 4'h0, 32'd380000);      // held change fires right
		send_sample(4'h4, 4'h0, 32'd390000);      // held change fires left
		send_sample(4'h0, 4'h0, 32'd400000);      // release
		send_sample(4'h0, 4'h0, 32'd500000);      // idle
		send_sample(4'h1, 4'h0, 32'd510000);      // change without press fires up
		send_sample(4'h1, 4'h0, 32'hFFFF_0000);   // huge step, minimum period
		send_sample(4'h1, 4'h0, 32'h0000_1000);   // stamp wraps
		send_sample(4'h1, 4'h0, 32'h0);           // zero stamp mid-hold
		send_sample(4'h1, 4'h0, 32'hFFFF_FFFF);   // hold time saturates
		send_sample(4'h0, 4'h2, 32'hFFFF_FFFF);   // press with nothing held
		send_sample(4'hF, 4'hF, 32'h8000_0000);   // every bit set
		send_sample(4'hF, 4'h0, 32'h8000_0001);
		send_sample(4'hA, 4'h5, 32'h8000_0002);   // pressed up and left: up
		send_sample(4'h0, 4'h0, 32'h8000_0003);
		clock_us = 32'h8000_0003;

		// Short timing, no idling
		apply_setting(24'd50000, 24'd30000, 24'd100000, 24'd250000, 24'd20000, 24'd10000);
		random_phase(110);

		// Moderate random timing, sender idling
		apply_setting(REG_W'($urandom_range(0, 300000)), REG_W'($urandom_range(1, 120000)),
			REG_W'($urandom_range(0, 400000)), REG_W'($urandom_range(0, 800000)),
			REG_W'($urandom_range(1, 80000)), REG_W'($urandom_range(1, 80000)));
		send_idle_pct = 85;
		random_phase(110);

		// All zero: repeat on every steady frame, receiver stalling
		apply_setting('0, '0, '0, '0, '0, '0);
		send_idle_pct = 0;
		recv_stall_pct = 85;
		random_phase(110);

		// All ones, both sides idling
		apply_setting('1, '1, '1, '1, '1, '1);
		send_idle_pct = 27;
		recv_stall_pct = 27;
		random_phase(110);

		// Full-range random timing; long receiver hold-off while samples keep coming
		apply_setting(REG_W'($urandom), REG_W'($urandom), REG_W'($urandom), REG_W'($urandom),
			REG_W'($urandom), REG_W'($urandom));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_req = 1'b1;
		repeat (20) play(DIR_W'($urandom_range(15)), DIR_W'($urandom_range(15)));
		drain();
		random_phase(90);

		// Moderate random timing, sender idling
		apply_setting(REG_W'($urandom_range(0, 300000)), REG_W'($urandom_range(1, 120000)),
			REG_W'($urandom_range(0, 400000)), REG_W'($urandom_range(0, 800000)),
			REG_W'($urandom_range(1, 80000)), REG_W'($urandom_range(1, 80000)));
		send_idle_pct = 85;
		random_phase(110);

		// Short timing, receiver stalling
		apply_setting(24'd40000, 24'd25000, 24'd80000, 24'd200000, 24'd15000, 24'd5000);
		send_idle_pct = 0;
		recv_stall_pct = 85;
		random_phase(110);

		// Back to the default timing, both sides idling
		apply_setting(RST_INITIAL_DELAY, RST_BASE_PERIOD, RST_FAST_THR_ONE, RST_FAST_THR_TWO,
			RST_MIDDLE_PERIOD, RST_MINIMUM_PERIOD);
		send_idle_pct = 27;
		recv_stall_pct = 27;
		random_phase(110);

		// Let the last results drain, then give the verdict
		drain();
		repeat (5) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
